FILE: hw/rtl/i2cbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
`default_nettype none

package i2cbe_pkg;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;
    localparam int TICKS_W     = 10;
    localparam int LIMIT_W     = 8;
    localparam int DELAY_W     = 12;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 10'd12;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd250;

    localparam logic CFG_TICKS_PER_UNIT = 1'b0;
    localparam logic CFG_ACK_TIMEOUT    = 1'b1;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_STOP  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_READ  = 3'd3,
        CMD_WACK  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6
    } cmd_t;

    typedef struct packed {
        logic       kind;
        cmd_t       command;
        logic [7:0] write_data;
        logic       sda_in;
    } item_t;

    // packed so that scl_level lands in bit 0
    typedef struct packed {
        logic       command_rejected;
        logic       ack_missing;
        logic [7:0] read_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_listening;
        logic       sda_level;
        logic       scl_level;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cbe_seq.sv
// Line sequencer: phase state, counters and the per-item next-state logic.
`default_nettype none

module i2cbe_seq
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    input  wire i2cbe_pkg::item_t                item,
    input  wire logic [i2cbe_pkg::TICKS_W-1:0]   ticks_per_unit,
    input  wire logic [i2cbe_pkg::LIMIT_W-1:0]   ack_limit,
    output i2cbe_pkg::result_t                   result
);
    import i2cbe_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_ST_A    = 5'd1,
        PH_ST_B    = 5'd2,
        PH_SP_A    = 5'd3,
        PH_SP_B    = 5'd4,
        PH_WA_A    = 5'd5,
        PH_WA_B    = 5'd6,
        PH_WA_POLL = 5'd7,
        PH_WT_A    = 5'd8,
        PH_WT_B    = 5'd9,
        PH_AK_A    = 5'd10,
        PH_AK_B    = 5'd11,
        PH_WB_SET  = 5'd12,
        PH_WB_HI   = 5'd13,
        PH_WB_LO   = 5'd14,
        PH_RB_LO   = 5'd15,
        PH_RB_HI   = 5'd16
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [3:0]         bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [7:0]         poll_reg, poll_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               inmode_reg, inmode_next;
    logic [7:0]         rxbyte_reg, rxbyte_next;

    logic [TICKS_W-1:0] unit_len;
    logic [DELAY_W-1:0] delay_1u, delay_2u, delay_4u, delay_dec;
    logic [3:0]         bit_inc;
    logic               done, missing, rejected;

    // unit length of zero acts as one; 4 * 1023 still fits the counter
    assign unit_len  = (ticks_per_unit == '0) ? TICKS_W'(1) : ticks_per_unit;
    assign delay_1u  = {2'b00, unit_len};
    assign delay_2u  = {1'b0, unit_len, 1'b0};
    assign delay_4u  = {unit_len, 2'b00};
    assign delay_dec = (delay_reg != '0) ? delay_reg - DELAY_W'(1) : '0;
    assign bit_inc   = bit_reg + 4'd1;

    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        delay_next  = delay_reg;
        poll_next   = poll_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        inmode_next = inmode_reg;
        rxbyte_next = rxbyte_reg;
        done        = 1'b0;
        missing     = 1'b0;
        rejected    = 1'b0;

        if (item_valid)
        begin
            if (item.kind == KIND_COMMAND)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    unique case (item.command)
                        CMD_START:
                        begin
                            inmode_next = 1'b0;
                            sda_next    = 1'b1;
                            scl_next    = 1'b1;
                            delay_next  = delay_4u;
                            phase_next  = PH_ST_A;
                        end
                        CMD_STOP:
                        begin
                            inmode_next = 1'b0;
                            scl_next    = 1'b0;
                            sda_next    = 1'b0;
                            delay_next  = delay_4u;
                            phase_next  = PH_SP_A;
                        end
                        CMD_WRITE:
                        begin
                            inmode_next = 1'b0;
                            scl_next    = 1'b0;
                            sda_next    = item.write_data[7];
                            shift_next  = {item.write_data[6:0], 1'b0};
                            bit_next    = 4'd0;
                            delay_next  = delay_2u;
                            phase_next  = PH_WB_SET;
                        end
                        CMD_READ:
                        begin
                            inmode_next = 1'b1;
                            shift_next  = 8'd0;
                            bit_next    = 4'd0;
                            scl_next    = 1'b0;
                            delay_next  = delay_2u;
                            phase_next  = PH_RB_LO;
                        end
                        CMD_WACK:
                        begin
                            inmode_next = 1'b1;
                            sda_next    = 1'b1;
                            poll_next   = 8'd0;
                            delay_next  = delay_4u;
                            phase_next  = PH_WA_A;
                        end
                        CMD_ACK, CMD_NACK:
                        begin
                            inmode_next = 1'b0;
                            scl_next    = 1'b0;
                            sda_next    = (item.command == CMD_NACK);
                            delay_next  = delay_2u;
                            phase_next  = PH_AK_A;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            else if (phase_reg == PH_WA_POLL)
            begin
                if (!item.sda_in)
                begin
                    scl_next   = 1'b0;
                    phase_next = PH_IDLE;
                    done       = 1'b1;
                end
                else if (poll_reg >= ack_limit)
                begin
                    inmode_next = 1'b0;
                    scl_next    = 1'b0;
                    sda_next    = 1'b0;
                    delay_next  = delay_4u;
                    phase_next  = PH_WT_A;
                end
                else
                begin
                    poll_next = poll_reg + 8'd1;
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                delay_next = delay_dec;
                if (delay_dec == '0)
                begin
                    unique case (phase_reg)
                        PH_ST_A:
                        begin
                            sda_next   = 1'b0;
                            delay_next = delay_4u;
                            phase_next = PH_ST_B;
                        end
                        PH_ST_B:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_SP_A, PH_WT_A:
                        begin
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                            delay_next = delay_4u;
                            phase_next = (phase_reg == PH_SP_A) ? PH_SP_B : PH_WT_B;
                        end
                        PH_SP_B:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_WT_B:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            missing    = 1'b1;
                        end
                        PH_WA_A:
                        begin
                            scl_next   = 1'b1;
                            delay_next = delay_4u;
                            phase_next = PH_WA_B;
                        end
                        PH_WA_B:
                        begin
                            poll_next  = 8'd0;
                            phase_next = PH_WA_POLL;
                        end
                        PH_AK_A, PH_WB_SET:
                        begin
                            scl_next   = 1'b1;
                            delay_next = delay_2u;
                            phase_next = (phase_reg == PH_AK_A) ? PH_AK_B : PH_WB_HI;
                        end
                        PH_AK_B:
                        begin
                            scl_next   = 1'b0;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        PH_WB_HI:
                        begin
                            scl_next   = 1'b0;
                            delay_next = delay_2u;
                            phase_next = PH_WB_LO;
                        end
                        PH_WB_LO:
                        begin
                            bit_next = bit_inc;
                            if (bit_inc >= 4'd8)
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                            end
                            else
                            begin
                                sda_next   = shift_reg[7];
                                shift_next = {shift_reg[6:0], 1'b0};
                                delay_next = delay_2u;
                                phase_next = PH_WB_SET;
                            end
                        end
                        PH_RB_LO:
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[6:0], item.sda_in};
                            delay_next = delay_1u;
                            phase_next = PH_RB_HI;
                        end
                        PH_RB_HI:
                        begin
                            bit_next = bit_inc;
                            if (bit_inc >= 4'd8)
                            begin
                                rxbyte_next = shift_reg;
                                phase_next  = PH_IDLE;
                                done        = 1'b1;
                            end
                            else
                            begin
                                scl_next   = 1'b0;
                                delay_next = delay_2u;
                                phase_next = PH_RB_LO;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bit_reg    <= 4'd0;
            shift_reg  <= 8'd0;
            delay_reg  <= '0;
            poll_reg   <= 8'd0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            inmode_reg <= 1'b0;
            rxbyte_reg <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            delay_reg  <= delay_next;
            poll_reg   <= poll_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            inmode_reg <= inmode_next;
            rxbyte_reg <= rxbyte_next;
        end
    end

    assign result.scl_level        = scl_next;
    assign result.sda_level        = sda_next;
    assign result.sda_listening    = inmode_next;
    assign result.busy_res         = (phase_next != PH_IDLE);
    assign result.done_res         = done;
    assign result.read_byte        = rxbyte_next;
    assign result.ack_missing      = missing;
    assign result.command_rejected = rejected;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cbe_out_skid.sv
// Output register with one skid entry between the sequencer and the result stream.
`default_nettype none

module i2cbe_out_skid
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire i2cbe_pkg::result_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output i2cbe_pkg::result_t        out_data
);
    import i2cbe_pkg::*;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_data_reg, skid_data_reg;
    logic    take, push;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign take      = out_valid_reg && out_ready;
    assign push      = in_valid && !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (push)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_master_bit_engine_top.sv
// Top level of the I2C master bit engine: config registers, sequencer, result buffer.
//
// Input stream (s_*): each request is one timer tick (s_tuser = 0) or one
// command (s_tuser = 1). Every request yields exactly one result request on
// the output stream (m_*) carrying the SCL/SDA drive levels and status flags.
// A command is only started while idle; one sent while busy is dropped and
// flagged as rejected. Waveform phases last 1, 2 or 4 delay units, each unit
// being ticks_per_delay_unit tick requests.
// Config channel (cfg_*): index 0 = ticks per delay unit, index 1 = ack
// timeout limit; always ready; to be written only while the engine is idle,
// which the block itself does not enforce. A result is registered in the output
// register, or in the skid entry when stalled. Throughput: one request per
// cycle while s_tready is high, set by the phase update feeding the output register.
// Stall: a skid entry holds one more result when m_tready is low; s_tready
// drops once it is occupied and the engine state holds.
// Reset: lines released high, engine idle, registers at 12 and 250.
`default_nettype none

module i2c_master_bit_engine_top
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [2:0] command, [10:3] write_data, [11] sda_in, [15:12] zero
    input  wire logic [i2cbe_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [0] kind
    input  wire logic                                s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] scl_level, [1] sda_level, [2] sda_listening, [3] busy_res,
    // [4] done_res, [12:5] read_byte, [13] ack_missing, [14] command_rejected,
    // [15] zero
    output logic [i2cbe_pkg::OUT_TDATA_W-1:0]        m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [i2cbe_pkg::TICKS_W-1:0]       cfg_data
);
    import i2cbe_pkg::*;

    logic [TICKS_W-1:0] ticks_reg;
    logic [LIMIT_W-1:0] limit_reg;
    item_t              item;
    result_t            seq_result, out_result;
    logic               accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_TICKS_PER_UNIT)
            begin
                ticks_reg <= cfg_data;
            end
            else
            begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
        end
    end

    assign item.kind       = s_tuser;
    assign item.command    = cmd_t'(s_tdata[2:0]);
    assign item.write_data = s_tdata[10:3];
    assign item.sda_in     = s_tdata[11];
    assign accept          = s_tvalid && s_tready;

    i2cbe_seq u_seq
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (accept),
        .item           (item),
        .ticks_per_unit (ticks_reg),
        .ack_limit      (limit_reg),
        .result         (seq_result)
    );

    i2cbe_out_skid u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (seq_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), out_result};

endmodule

`default_nettype wire

FILE: hw/rtl/i2cbe_checker.sv
// Port-level checks for the I2C master bit engine, bound to the top level.
`default_nettype none

module i2cbe_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // every accepted request leaves a result pending next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request produced no result");

    // a stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> !m_tdata[3])
        else $error("done reported while still busy");

    a_missing_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[4])
        else $error("missing ack without completion");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> m_tdata[3] && !m_tdata[4])
        else $error("rejected command while idle");

endmodule

bind i2c_master_bit_engine_top i2cbe_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: tb/i2c_master_bit_engine_top_tb.sv
// Self-checking testbench for the I2C master bit engine: directed table, random frames, predictor.
`timescale 1ns / 100ps

module i2c_master_bit_engine_top_tb;
    import i2cbe_pkg::*;

    localparam logic [2:0] CMD_UNUSED = 3'd7;

    typedef enum logic [4:0] {
        SEQ_IDLE,
        START_HOLD,
        START_FALL,
        STOP_RISE,
        STOP_HOLD,
        ACKW_RISE,
        ACKW_HOLD,
        ACKW_POLL,
        TOUT_RISE,
        TOUT_HOLD,
        ACKS_RISE,
        ACKS_FALL,
        WR_RISE,
        WR_FALL,
        WR_NEXT,
        RD_RISE,
        RD_NEXT
    } seq_t;

    typedef struct {
        logic       kind;
        logic [2:0] cmd;
        logic [7:0] data;
        logic       sda;
        int         reps;
        logic       typed;
        result_t    want;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic                   cfg_index;
    logic [TICKS_W-1:0]     cfg_data;

    // predictor state
    seq_t               sq_phase;
    logic [3:0]         sq_bits;
    logic [7:0]         sq_shift;
    logic [DELAY_W-1:0] sq_wait;
    logic [7:0]         sq_polls;
    logic               ln_scl;
    logic               ln_sda;
    logic               ln_listen;
    logic [7:0]         rd_byte;
    logic               ev_done;
    logic               ev_missing;
    logic [TICKS_W-1:0] reg_unit;
    logic [LIMIT_W-1:0] reg_limit;

    result_t pending_levels [$];
    int      mismatches;
    int      results_seen;
    int      tx_gap_pct;

    logic [2:0] frame_cmds [8] = '{CMD_START, CMD_WRITE, CMD_WACK, CMD_READ,
                                   CMD_ACK, CMD_READ, CMD_NACK, CMD_STOP};
    logic [2:0] slow_cmds [3] = '{CMD_ACK, CMD_NACK, CMD_NACK};
    int         ack_odds_set [4] = '{0, 3, 40, 1000};

    int unit_set [8]  = '{1, 2, 0, 1, 3, 128, 5, 12};
    int limit_set [8] = '{0, 1, 3, 255, 7, 9, 0, 250};
    int gap_set [8]   = '{0, 30, 10, 50, 0, 0, 20, 30};

    // directed plan at reset settings: 12 ticks per unit, timeout 250
    row_t plan [9] = '{
        '{KIND_TICK,    CMD_START,  8'h00, 1'b0,   1, 1'b1, 15'h0003},
        '{KIND_COMMAND, CMD_UNUSED, 8'h00, 1'b0,   1, 1'b1, 15'h0003},
        '{KIND_COMMAND, CMD_START,  8'h00, 1'b0,   1, 1'b1, 15'h000B},
        '{KIND_COMMAND, CMD_STOP,   8'h00, 1'b0,   1, 1'b1, 15'h400B},
        '{KIND_TICK,    CMD_START,  8'h00, 1'b0, 100, 1'b0, 15'h0000},
        '{KIND_COMMAND, CMD_WACK,   8'h00, 1'b1,   1, 1'b0, 15'h0000},
        '{KIND_TICK,    CMD_START,  8'h00, 1'b1, 520, 1'b0, 15'h0000},
        '{KIND_COMMAND, CMD_NACK,   8'h00, 1'b0,   1, 1'b0, 15'h0000},
        '{KIND_TICK,    CMD_START,  8'h00, 1'b0,  60, 1'b0, 15'h0000}
    };

    i2c_master_bit_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void arm_wait(input int units);
        int t;
        t = (reg_unit == '0) ? 1 : int'(reg_unit);
        sq_wait = DELAY_W'(units * t);
        if (sq_wait == '0)
            sq_wait = 12'd1;
    endfunction

    function automatic void wrap_up(input logic missing);
        sq_phase   = SEQ_IDLE;
        ev_done    = 1'b1;
        ev_missing = missing;
    endfunction

    function automatic void shift_out();
        ln_sda   = sq_shift[7];
        sq_shift = {sq_shift[6:0], 1'b0};
    endfunction

    function automatic void launch_command(input logic [2:0] cmd, input logic [7:0] data);
        case (cmd)
            CMD_START:
            begin
                ln_listen = 1'b0; ln_sda = 1'b1; ln_scl = 1'b1;
                arm_wait(4); sq_phase = START_HOLD;
            end
            CMD_STOP:
            begin
                ln_listen = 1'b0; ln_scl = 1'b0; ln_sda = 1'b0;
                arm_wait(4); sq_phase = STOP_RISE;
            end
            CMD_WRITE:
            begin
                ln_listen = 1'b0; ln_scl = 1'b0; sq_shift = data; sq_bits = '0;
                shift_out(); arm_wait(2); sq_phase = WR_RISE;
            end
            CMD_READ:
            begin
                ln_listen = 1'b1; sq_shift = '0; sq_bits = '0; ln_scl = 1'b0;
                arm_wait(2); sq_phase = RD_RISE;
            end
            CMD_WACK:
            begin
                ln_listen = 1'b1; ln_sda = 1'b1; sq_polls = '0;
                arm_wait(4); sq_phase = ACKW_RISE;
            end
            CMD_ACK, CMD_NACK:
            begin
                ln_listen = 1'b0; ln_scl = 1'b0; ln_sda = (cmd == CMD_NACK);
                arm_wait(2); sq_phase = ACKS_RISE;
            end
            default: ;
        endcase
    endfunction

    function automatic void step_line();
        case (sq_phase)
            START_HOLD: begin ln_sda = 1'b0; arm_wait(4); sq_phase = START_FALL; end
            START_FALL: begin ln_scl = 1'b0; wrap_up(1'b0); end
            STOP_RISE:  begin ln_scl = 1'b1; ln_sda = 1'b1; arm_wait(4); sq_phase = STOP_HOLD; end
            STOP_HOLD:  wrap_up(1'b0);
            ACKW_RISE:  begin ln_scl = 1'b1; arm_wait(4); sq_phase = ACKW_HOLD; end
            ACKW_HOLD:  begin sq_polls = '0; sq_phase = ACKW_POLL; end
            TOUT_RISE:  begin ln_scl = 1'b1; ln_sda = 1'b1; arm_wait(4); sq_phase = TOUT_HOLD; end
            TOUT_HOLD:  wrap_up(1'b1);
            ACKS_RISE:  begin ln_scl = 1'b1; arm_wait(2); sq_phase = ACKS_FALL; end
            ACKS_FALL:  begin ln_scl = 1'b0; wrap_up(1'b0); end
            WR_RISE:    begin ln_scl = 1'b1; arm_wait(2); sq_phase = WR_FALL; end
            WR_FALL:    begin ln_scl = 1'b0; arm_wait(2); sq_phase = WR_NEXT; end
            WR_NEXT:
            begin
                sq_bits = sq_bits + 4'd1;
                if (sq_bits >= 4'd8)
                    wrap_up(1'b0);
                else
                begin
                    shift_out(); arm_wait(2); sq_phase = WR_RISE;
                end
            end
            default: sq_phase = SEQ_IDLE;
        endcase
    endfunction

    function automatic void step_read(input logic sda);
        if (sq_phase == RD_RISE)
        begin
            ln_scl   = 1'b1;
            sq_shift = {sq_shift[6:0], sda};
            arm_wait(1);
            sq_phase = RD_NEXT;
        end
        else
        begin
            sq_bits = sq_bits + 4'd1;
            if (sq_bits >= 4'd8)
            begin
                rd_byte = sq_shift;
                wrap_up(1'b0);
            end
            else
            begin
                ln_scl = 1'b0; arm_wait(2); sq_phase = RD_RISE;
            end
        end
    endfunction

    function automatic void poll_ack(input logic sda);
        if (!sda)
        begin
            ln_scl = 1'b0;
            wrap_up(1'b0);
        end
        else if (sq_polls >= reg_limit)
        begin
            ln_listen = 1'b0; ln_scl = 1'b0; ln_sda = 1'b0;
            arm_wait(4); sq_phase = TOUT_RISE;
        end
        else
            sq_polls = sq_polls + 8'd1;
    endfunction

    function automatic result_t predict_lines(input logic kind, input logic [2:0] cmd,
                                              input logic [7:0] data, input logic sda);
        result_t r;
        logic    rejected;
        ev_done    = 1'b0;
        ev_missing = 1'b0;
        rejected   = 1'b0;
        if (kind == KIND_COMMAND)
        begin
            if (sq_phase != SEQ_IDLE)
                rejected = 1'b1;
            else
                launch_command(cmd, data);
        end
        else if (sq_phase == ACKW_POLL)
            poll_ack(sda);
        else if (sq_phase != SEQ_IDLE)
        begin
            if (sq_wait != '0)
                sq_wait = sq_wait - 12'd1;
            if (sq_wait == '0)
            begin
                if (sq_phase == RD_RISE || sq_phase == RD_NEXT)
                    step_read(sda);
                else
                    step_line();
            end
        end
        r.scl_level        = ln_scl;
        r.sda_level        = ln_sda;
        r.sda_listening    = ln_listen;
        r.busy_res         = (sq_phase != SEQ_IDLE);
        r.done_res         = ev_done;
        r.read_byte        = rd_byte;
        r.ack_missing      = ev_missing;
        r.command_rejected = rejected;
        return r;
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic take_result(input logic [OUT_TDATA_W-1:0] raw);
        result_t got;
        result_t want;
        got = result_t'(raw[14:0]);
        results_seen++;
        if (pending_levels.size() == 0)
        begin
            report("unexpected result", raw, 0);
            return;
        end
        want = pending_levels.pop_front();
        if (got.scl_level !== want.scl_level)
            report("scl_level", got.scl_level, want.scl_level);
        if (got.sda_level !== want.sda_level)
            report("sda_level", got.sda_level, want.sda_level);
        if (got.sda_listening !== want.sda_listening)
            report("sda_listening", got.sda_listening, want.sda_listening);
        if (got.busy_res !== want.busy_res)
            report("busy_res", got.busy_res, want.busy_res);
        if (got.done_res !== want.done_res)
            report("done_res", got.done_res, want.done_res);
        if (got.read_byte !== want.read_byte)
            report("read_byte", got.read_byte, want.read_byte);
        if (got.ack_missing !== want.ack_missing)
            report("ack_missing", got.ack_missing, want.ack_missing);
        if (got.command_rejected !== want.command_rejected)
            report("command_rejected", got.command_rejected, want.command_rejected);
        if (raw[15] !== 1'b0)
            report("pad bit", raw[15], 0);
    endtask

    task automatic send_item(input logic kind, input logic [2:0] cmd, input logic [7:0] data,
                             input logic sda, input logic typed, input result_t want);
        int      gap;
        result_t got;
        gap = pick_gap(tx_gap_pct);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0000, sda, data, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        got = predict_lines(kind, cmd, data, sda);
        pending_levels.push_back(typed ? want : got);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [TICKS_W-1:0] unit, input logic [LIMIT_W-1:0] limit);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_TICKS_PER_UNIT;
        cfg_data  <= unit;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_unit  = unit;
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_data  <= {2'($urandom_range(0, 3)), limit};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_limit = limit;
        cfg_valid <= 1'b0;
    endtask

    // one command per pass, then ticks (with the odd stray command) until the predicted sequence is over
    task automatic run_frames(input int target, input bit slow);
        int         sent;
        int         frame_pos;
        int         ack_odds;
        logic [2:0] cmd;
        logic       sda;
        sent      = 0;
        frame_pos = 0;
        while (sent < target)
        begin
            if (slow)
                cmd = slow_cmds[$urandom_range(0, 2)];
            else if ($urandom_range(0, 3) != 0)
            begin
                cmd = frame_cmds[frame_pos];
                frame_pos = (frame_pos + 1) % 8;
            end
            else if ($urandom_range(0, 9) == 0)
                cmd = CMD_UNUSED;
            else
                cmd = 3'($urandom_range(0, 6));
            ack_odds = ack_odds_set[$urandom_range(0, 3)];
            send_item(KIND_COMMAND, cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'b0, '0);
            sent++;
            while (sq_phase != SEQ_IDLE)
            begin
                if ($urandom_range(0, 32) == 0)
                    send_item(KIND_COMMAND, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'b0, '0);
                else
                begin
                    if (sq_phase == ACKW_POLL)
                        sda = ($urandom_range(0, ack_odds) != 0);
                    else
                        sda = 1'($urandom_range(0, 1));
                    send_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                              sda, 1'b0, '0);
                end
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                send_item(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    // result side: random back-pressure plus one long hold
    initial
    begin : sink
        int stall_left;
        int window;
        int stall_pct;
        bit held;
        stall_left = 0;
        window     = 0;
        stall_pct  = 0;
        held       = 1'b0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                take_result(m_tdata);
            if (!held && results_seen >= 300)
            begin
                held       = 1'b1;
                stall_left = 300;
            end
            if (window == 0)
            begin
                window    = 300;
                stall_pct = ack_odds_set[$urandom_range(0, 2)] * 5;
            end
            window--;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                stall_left = pick_gap(100) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_TICK;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_TICKS_PER_UNIT;
        cfg_data   = '0;
        rst_n      = 1'b0;
        mismatches = 0;
        results_seen = 0;
        tx_gap_pct = 20;
        sq_phase   = SEQ_IDLE;
        sq_bits    = '0;
        sq_shift   = '0;
        sq_wait    = '0;
        sq_polls   = '0;
        ln_scl     = 1'b1;
        ln_sda     = 1'b1;
        ln_listen  = 1'b0;
        rd_byte    = '0;
        ev_done    = 1'b0;
        ev_missing = 1'b0;
        reg_unit   = TICKS_RESET;
        reg_limit  = LIMIT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            repeat (plan[i].reps)
                send_item(plan[i].kind, plan[i].cmd, plan[i].data, plan[i].sda,
                          plan[i].typed, plan[i].want);

        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            if (p == 6)
                set_config(TICKS_W'($urandom_range(1, 6)), LIMIT_W'($urandom_range(0, 255)));
            else
                set_config(TICKS_W'(unit_set[p]), LIMIT_W'(limit_set[p]));
            tx_gap_pct = gap_set[p];
            run_frames((unit_set[p] > 100) ? 1 : 100, unit_set[p] > 100);
        end

        drain_results();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
